// ===== rtl/q2rm_pkg.sv =====
// shared types and constants for the quaternion to rotation matrix block
`default_nettype none
package q2rm_pkg;

    localparam int COMP_W  = 16;  // quaternion component width
    localparam int ENT_W   = 16;  // matrix entry width
    localparam int N_ENT   = 9;   // entries per matrix
    localparam int PROD_W  = 32;  // signed product of two components
    localparam int SUM_W   = 34;  // signed numerator before taking magnitude
    localparam int REM_W   = 33;  // norm and partial remainder
    localparam int Q_W     = 32;  // quotient bits, enough for the widest fraction setting

    // per-entry state carried through the divider stages
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
        logic             neg;
    } t_lane;

endpackage
`default_nettype wire

// ===== rtl/quat_to_rotation_matrix.sv =====
// quaternion to 3x3 rotation matrix, pipelined with a restoring divider
//
// channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+---------------------------------------
// input    | in  | i_s_tvalid / o_s_tready      | i_s_tdata: quat_w, quat_x, quat_y, quat_z
// result   | out | o_m_tvalid / i_m_tready      | o_m_tdata: entry_00..entry_22, o_m_tuser: zero_norm
//
// one quaternion per cycle while the result channel is not stalled; the stages are products,
// norm and numerators, (FRAC_BITS+2)/4 rounded up divider stages of four quotient bits each,
// and rounding
// the divider stages, nine 34-bit compare and subtract chains of four steps, set the clock
// each stage holds its item while the one after it is full, so stalls drop and repeat nothing
// reset (synchronous, active low) clears only the valid bits
`default_nettype none
module quat_to_rotation_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [63:0]  i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [143:0]      o_m_tdata,   // entry_00, 01, 02, 10, 11, 12, 20, 21, 22
    output logic [0:0]        o_m_tuser    // zero_norm
);

    localparam int SPS   = 4;
    localparam int NSTEP = FRAC_BITS + 2;
    localparam int ND    = (NSTEP + SPS - 1) / SPS;
    localparam int L     = ND + 3;
    localparam int EW    = q2rm_pkg::ENT_W;
    localparam int RW    = q2rm_pkg::REM_W;
    localparam int QW    = q2rm_pkg::Q_W;
    localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    logic [L-1:0] r_v;
    logic [L-1:0] en;

    always_comb begin
        en[L-1] = !r_v[L-1] || i_m_tready;
        for (int k = L - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_s_tvalid;
            for (int k = 1; k < L; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_s_tready = en[0];

    // stage 0: the ten products
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = i_s_tdata[15:0];
    assign qx = i_s_tdata[31:16];
    assign qy = i_s_tdata[47:32];
    assign qz = i_s_tdata[63:48];

    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_wy, r_wz, r_xy, r_xz, r_yz;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ww <= qw * qw;  r_xx <= qx * qx;  r_yy <= qy * qy;  r_zz <= qz * qz;
            r_wx <= qw * qx;  r_wy <= qw * qy;  r_wz <= qw * qz;
            r_xy <= qx * qy;  r_xz <= qx * qz;  r_yz <= qy * qz;
        end
    end

    // stage 1: norm and numerators; off-diagonal ones doubled so all share one scale
    logic signed [33:0] num [q2rm_pkg::N_ENT];
    logic signed [33:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz, nsum;

    always_comb begin
        ww = 34'(r_ww);  xx = 34'(r_xx);  yy = 34'(r_yy);  zz = 34'(r_zz);
        wx = 34'(r_wx);  wy = 34'(r_wy);  wz = 34'(r_wz);
        xy = 34'(r_xy);  xz = 34'(r_xz);  yz = 34'(r_yz);
        nsum   = ww + xx + yy + zz;
        num[0] = ww + xx - yy - zz;
        num[1] = (xy - wz) <<< 1;
        num[2] = (xz + wy) <<< 1;
        num[3] = (xy + wz) <<< 1;
        num[4] = ww - xx + yy - zz;
        num[5] = (yz - wx) <<< 1;
        num[6] = (xz - wy) <<< 1;
        num[7] = (yz + wx) <<< 1;
        num[8] = ww - xx - yy + zz;
    end

    q2rm_pkg::t_lane   r_lane [ND+1][q2rm_pkg::N_ENT];
    logic [RW-1:0]     r_n    [ND+1];
    logic              r_zero [ND+1];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_n[0]    <= nsum[RW-1:0];
            r_zero[0] <= (nsum == '0);
            for (int e = 0; e < q2rm_pkg::N_ENT; e++) begin
                r_lane[0][e].neg <= num[e][33];
                r_lane[0][e].rem <= num[e][33] ? RW'(-num[e]) : num[e][RW-1:0];
                r_lane[0][e].quo <= '0;
            end
        end
    end

    // divider stages, four quotient bits each (fewer in the last when FRAC_BITS+2 is not a multiple of four)
    for (genvar d = 1; d <= ND; d++) begin : g_div
        q2rm_pkg::t_lane nx [q2rm_pkg::N_ENT];

        always_comb begin
            logic [RW:0]   trial;
            logic [RW-1:0] rem;
            logic [QW-1:0] quo;
            logic          ge;
            for (int e = 0; e < q2rm_pkg::N_ENT; e++) begin
                rem = r_lane[d-1][e].rem;
                quo = r_lane[d-1][e].quo;
                for (int k = 0; k < SPS; k++) begin
                    if ((d - 1) * SPS + k < NSTEP) begin
                        // the first step takes the integer bit without doubling
                        trial = ((d - 1) * SPS + k == 0) ? {1'b0, rem} : {rem, 1'b0};
                        ge    = trial >= {1'b0, r_n[d-1]};
                        if (ge) trial = trial - {1'b0, r_n[d-1]};
                        rem   = trial[RW-1:0];
                        quo   = {quo[QW-2:0], ge};
                    end
                end
                nx[e].rem = rem;
                nx[e].quo = quo;
                nx[e].neg = r_lane[d-1][e].neg;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[d+1]) begin
                r_n[d]    <= r_n[d-1];
                r_zero[d] <= r_zero[d-1];
                for (int e = 0; e < q2rm_pkg::N_ENT; e++) begin
                    r_lane[d][e] <= nx[e];
                end
            end
        end
    end

    // output stage: round half away from zero, restore sign, identity on zero norm
    logic [EW-1:0] ent [q2rm_pkg::N_ENT];

    always_comb begin
        logic [QW:0]         qr;
        logic signed [47:0]  val;
        for (int e = 0; e < q2rm_pkg::N_ENT; e++) begin
            qr  = ({1'b0, r_lane[ND][e].quo} + (QW+1)'(1)) >> 1;
            val = signed'(48'(qr));
            if (r_lane[ND][e].neg) val = -val;
            if (r_zero[ND]) begin
                ent[e] = (e == 0 || e == 4 || e == 8) ? ONE : '0;
            end else begin
                ent[e] = val[EW-1:0];
            end
        end
    end

    logic [143:0] r_out;
    logic         r_zn;

    always_ff @(posedge i_clk) begin
        if (en[L-1]) begin
            for (int e = 0; e < q2rm_pkg::N_ENT; e++) begin
                r_out[e*EW +: EW] <= ent[e];
            end
            r_zn <= r_zero[ND];
        end
    end

    assign o_m_tvalid   = r_v[L-1];
    assign o_m_tdata    = r_out;
    assign o_m_tuser[0] = r_zn;

endmodule
`default_nettype wire
